FILE: src/dmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types and constants for the direct-mapped write-back line cache:
// request and result transfer formats, function codes and update controls.
// ----------------------------------------------------------------------------
package dmc_pkg;

  // Default geometry: 2^15 lines of eight 32-bit words, 32-bit byte address.
  localparam int SET_IDX_W_DEF    = 15;
  localparam int OFFSET_BITS_DEF  = 5;
  localparam int LINE_WORDS_DEF   = 8;
  localparam int ADDRESS_BITS_DEF = 32;

  // Fixed transfer format: eight word slots of 32 bits each.
  localparam int WORD_W   = 32;
  localparam int IO_WORDS = 8;

  // Function codes.
  localparam logic FUNC_ACCESS = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  // One request transfer.
  typedef struct packed {
    logic              func;
    logic [31:0]       address;
    logic              read_enable;
    logic              write_enable;
    logic [WORD_W-1:0] write_word_0;
    logic [WORD_W-1:0] write_word_1;
    logic [WORD_W-1:0] write_word_2;
    logic [WORD_W-1:0] write_word_3;
    logic [WORD_W-1:0] write_word_4;
    logic [WORD_W-1:0] write_word_5;
    logic [WORD_W-1:0] write_word_6;
    logic [WORD_W-1:0] write_word_7;
  } in_t;

  // One result transfer.
  typedef struct packed {
    logic              hit;
    logic              writeback_needed;
    logic [31:0]       writeback_address;
    logic [WORD_W-1:0] line_word_0;
    logic [WORD_W-1:0] line_word_1;
    logic [WORD_W-1:0] line_word_2;
    logic [WORD_W-1:0] line_word_3;
    logic [WORD_W-1:0] line_word_4;
    logic [WORD_W-1:0] line_word_5;
    logic [WORD_W-1:0] line_word_6;
    logic [WORD_W-1:0] line_word_7;
  } out_t;

  // Store updates decided by the resolve unit.
  typedef struct packed {
    logic meta_we;    // write valid, dirty and tag of the line
    logic line_we;    // overwrite the line data
    logic set_dirty;  // dirty value written with the metadata
  } upd_t;

endpackage

FILE: src/direct_mapped_writeback_cache_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache_top
// Direct-mapped write-back line cache with a sequenced lookup and update
// over single metadata and line memories.
// ----------------------------------------------------------------------------
//   Channel   Ports                        Direction  Moves
//   request   in_valid/in_ready/in_data    in         one access or insert
//   result    out_valid/out_ready/out_data out        one result per request
//
// After reset a clearing pass writes every metadata entry, with in_ready low
// throughout. A request goes through the registered read of both memories,
// then the compare and update step that also loads the output register.
// A new request is taken while a result still waits in the output register;
// the update cycle stalls only if that register is still occupied.
// Reset is synchronous, active low, on rst_n.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache_top #(
  parameter int SET_IDX_W    = dmc_pkg::SET_IDX_W_DEF,
  parameter int OFFSET_BITS  = dmc_pkg::OFFSET_BITS_DEF,
  parameter int LINE_WORDS   = dmc_pkg::LINE_WORDS_DEF,
  parameter int ADDRESS_BITS = dmc_pkg::ADDRESS_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dmc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dmc_pkg::out_t out_data
);

  localparam int TAG_REAL = ADDRESS_BITS - SET_IDX_W - OFFSET_BITS;
  localparam int TAG_W    = (TAG_REAL > 0) ? TAG_REAL : 1;
  localparam int META_W   = TAG_W + 2;
  localparam int LINE_W   = LINE_WORDS * dmc_pkg::WORD_W;
  localparam int DEPTH    = 1 << SET_IDX_W;
  localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDRESS_BITS) - 64'd1);

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [SET_IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;
  dmc_pkg::in_t         req_r;
  logic                 out_valid_r, out_valid_nxt;
  dmc_pkg::out_t        out_data_r;

  logic                 in_xfer;
  logic                 upd_go;
  logic [31:0]          in_addr_m;
  logic [31:0]          req_addr_m;
  logic [SET_IDX_W-1:0] in_idx;
  logic [SET_IDX_W-1:0] req_idx;
  logic [TAG_W-1:0]     req_tag;

  logic                 meta_we;
  logic [SET_IDX_W-1:0] meta_waddr;
  logic [META_W-1:0]    meta_wdata;
  logic [META_W-1:0]    meta_rd;
  logic                 line_we;
  logic [LINE_W-1:0]    line_wdata;
  logic [LINE_W-1:0]    line_rd;
  dmc_pkg::out_t        result;
  dmc_pkg::upd_t        upd;

  // Address split; bits above the address width are ignored.
  assign in_addr_m  = in_data.address & ADDR_MASK;
  assign req_addr_m = req_r.address & ADDR_MASK;
  assign in_idx     = in_addr_m[OFFSET_BITS +: SET_IDX_W];
  assign req_idx    = req_addr_m[OFFSET_BITS +: SET_IDX_W];

  if (TAG_REAL > 0) begin : g_tag
    assign req_tag = req_addr_m[OFFSET_BITS + SET_IDX_W +: TAG_W];
  end else begin : g_no_tag
    assign req_tag = '0;
  end

  // Handshake.
  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign upd_go    = (state_r == ST_UPDATE) && (!out_valid_r || out_ready);

  // Sequencer: clearing pass, wait for a request, then resolve and update.
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (upd_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Output register: loaded by the update, emptied by a result transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (upd_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r <= in_data;
    end
    if (upd_go) begin
      out_data_r <= result;
    end
  end

  // Metadata write: clearing pass, or the decided update.
  always_comb begin
    if (state_r == ST_CLEAR) begin
      meta_we    = 1'b1;
      meta_waddr = clr_cnt_r;
      meta_wdata = '0;
    end else begin
      meta_we    = upd_go && upd.meta_we;
      meta_waddr = req_idx;
      meta_wdata = {1'b1, upd.set_dirty, req_tag};
    end
  end

  assign line_we = upd_go && upd.line_we;

  // Valid, dirty and tag of each line.
  dmc_ram #(
    .WIDTH (META_W),
    .DEPTH (DEPTH)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (in_xfer),
    .raddr (in_idx),
    .rdata (meta_rd)
  );

  // Line data.
  dmc_ram #(
    .WIDTH (LINE_W),
    .DEPTH (DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (req_idx),
    .wdata (line_wdata),
    .re    (in_xfer),
    .raddr (in_idx),
    .rdata (line_rd)
  );

  // Tag compare and result formation.
  dmc_resolve #(
    .SET_IDX_W    (SET_IDX_W),
    .OFFSET_BITS  (OFFSET_BITS),
    .LINE_WORDS   (LINE_WORDS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_resolve (
    .req        (req_r),
    .req_idx    (req_idx),
    .req_tag    (req_tag),
    .meta_rd    (meta_rd),
    .line_rd    (line_rd),
    .line_wdata (line_wdata),
    .result     (result),
    .upd        (upd)
  );

  // No result may appear during the clearing pass.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r)
    else $error("result valid during clearing pass");

  // An accepted request always moves the sequencer to the update state in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_UPDATE))
    else $error("accepted request not followed by update");

  // An update blocked by a full output register waits and writes nothing.
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_UPDATE) && out_valid_r && !out_ready)
      |-> (!line_we && !meta_we) ##1 (state_r == ST_UPDATE))
    else $error("stalled update advanced or wrote a store");

  // Line data is never written without its metadata.
  assert property (@(posedge clk) disable iff (!rst_n)
    line_we |-> (meta_we && (state_r == ST_UPDATE)))
    else $error("line write without metadata write");

endmodule

FILE: src/dmc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that updates only when the read enable is high.
// ----------------------------------------------------------------------------
module dmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/dmc_resolve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_resolve
// Tag compare and decision unit: from the stored metadata and line of the
// addressed set it forms the result transfer and the store updates.
// ----------------------------------------------------------------------------
module dmc_resolve #(
  parameter int SET_IDX_W    = dmc_pkg::SET_IDX_W_DEF,
  parameter int OFFSET_BITS  = dmc_pkg::OFFSET_BITS_DEF,
  parameter int LINE_WORDS   = dmc_pkg::LINE_WORDS_DEF,
  parameter int ADDRESS_BITS = dmc_pkg::ADDRESS_BITS_DEF
) (
  input  dmc_pkg::in_t                                      req,
  input  logic [SET_IDX_W-1:0]                              req_idx,
  input  logic [((ADDRESS_BITS-SET_IDX_W-OFFSET_BITS) > 0 ?
                 (ADDRESS_BITS-SET_IDX_W-OFFSET_BITS) : 1)-1:0] req_tag,
  input  logic [((ADDRESS_BITS-SET_IDX_W-OFFSET_BITS) > 0 ?
                 (ADDRESS_BITS-SET_IDX_W-OFFSET_BITS) : 1)+1:0] meta_rd,
  input  logic [LINE_WORDS*dmc_pkg::WORD_W-1:0]             line_rd,
  output logic [LINE_WORDS*dmc_pkg::WORD_W-1:0]             line_wdata,
  output dmc_pkg::out_t                                     result,
  output dmc_pkg::upd_t                                     upd
);

  localparam int TAG_REAL = ADDRESS_BITS - SET_IDX_W - OFFSET_BITS;
  localparam int TAG_W    = (TAG_REAL > 0) ? TAG_REAL : 1;
  localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDRESS_BITS) - 64'd1);

  logic                                      old_valid;
  logic                                      old_dirty;
  logic [TAG_W-1:0]                          old_tag;
  logic                                      tag_hit;
  logic                                      show_line;
  logic [dmc_pkg::IO_WORDS-1:0][dmc_pkg::WORD_W-1:0] wwords;
  logic [dmc_pkg::IO_WORDS-1:0][dmc_pkg::WORD_W-1:0] owords;

  assign old_valid = meta_rd[TAG_W+1];
  assign old_dirty = meta_rd[TAG_W];
  assign old_tag   = meta_rd[TAG_W-1:0];

  // With no tag bits the stored and requested tags are both zero.
  assign tag_hit = old_valid && (old_tag == req_tag);

  // Incoming words, slot order.
  assign wwords = {req.write_word_7, req.write_word_6, req.write_word_5,
                   req.write_word_4, req.write_word_3, req.write_word_2,
                   req.write_word_1, req.write_word_0};

  // Old line goes out on a read hit or on a dirty eviction.
  always_comb begin
    show_line = 1'b0;
    upd       = '0;
    result    = '0;
    if (req.func == dmc_pkg::FUNC_ACCESS) begin
      result.hit = tag_hit;
      show_line  = tag_hit && req.read_enable;
      if (tag_hit && req.write_enable) begin
        upd.meta_we   = 1'b1;
        upd.line_we   = 1'b1;
        upd.set_dirty = 1'b1;
      end
    end else begin
      show_line               = old_valid && old_dirty;
      result.writeback_needed = old_valid && old_dirty;
      if (old_valid && old_dirty) begin
        result.writeback_address = ((32'(old_tag) << (OFFSET_BITS + SET_IDX_W))
                                   | (32'(req_idx) << OFFSET_BITS)) & ADDR_MASK;
      end
      upd.meta_we   = 1'b1;
      upd.line_we   = 1'b1;
      upd.set_dirty = 1'b0;
    end
    result.line_word_0 = owords[0];
    result.line_word_1 = owords[1];
    result.line_word_2 = owords[2];
    result.line_word_3 = owords[3];
    result.line_word_4 = owords[4];
    result.line_word_5 = owords[5];
    result.line_word_6 = owords[6];
    result.line_word_7 = owords[7];
  end

  // Word slots: those beyond the line width read zero and are never stored.
  for (genvar i = 0; i < dmc_pkg::IO_WORDS; i++) begin : g_slot
    if (i < LINE_WORDS) begin : g_used
      assign owords[i] = show_line ? line_rd[i*dmc_pkg::WORD_W +: dmc_pkg::WORD_W]
                                   : '0;
      assign line_wdata[i*dmc_pkg::WORD_W +: dmc_pkg::WORD_W] = wwords[i];
    end else begin : g_unused
      assign owords[i] = '0;
    end
  end

endmodule

FILE: sim/cache_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cache_result_checker
// Watches the request and result channels of the direct-mapped write-back
// cache, keeps its own copy of the line, tag, valid and dirty stores, works
// out the result of every accepted request and compares each accepted result
// transfer, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module cache_result_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  dmc_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  dmc_pkg::out_t out_data,
  output int            mismatch_count,
  output int            pending_count
);

  localparam int INDEX_W   = dmc_pkg::SET_IDX_W_DEF;
  localparam int OFFSET_W  = dmc_pkg::OFFSET_BITS_DEF;
  localparam int TAG_LSB   = OFFSET_W + INDEX_W;
  localparam int TAG_W     = dmc_pkg::ADDRESS_BITS_DEF - TAG_LSB;
  localparam int NUM_LINES = 1 << INDEX_W;
  localparam int LINE_W    = dmc_pkg::WORD_W * dmc_pkg::IO_WORDS;

  // Shadow copy of the cache stores.
  bit              line_valid [NUM_LINES];
  bit              line_dirty [NUM_LINES];
  bit [TAG_W-1:0]  line_tag   [NUM_LINES];
  bit [LINE_W-1:0] line_data  [NUM_LINES];

  dmc_pkg::out_t expected_results [$];
  int            mismatches = 0;

  // Places a whole line in the word fields of a result, word 0 lowest.
  function automatic dmc_pkg::out_t with_line_words(dmc_pkg::out_t res,
                                                    logic [LINE_W-1:0] words);
    dmc_pkg::out_t upd;
    upd = res;
    {upd.line_word_7, upd.line_word_6, upd.line_word_5, upd.line_word_4,
     upd.line_word_3, upd.line_word_2, upd.line_word_1, upd.line_word_0} = words;
    return upd;
  endfunction

  // Works out the result of one request and applies it to the shadow stores.
  function automatic dmc_pkg::out_t predict_cache_result(dmc_pkg::in_t req);
    dmc_pkg::out_t      res;
    logic [INDEX_W-1:0] idx;
    logic [TAG_W-1:0]   tag;
    logic [LINE_W-1:0]  words;
    res   = '0;
    idx   = req.address[OFFSET_W +: INDEX_W];
    tag   = req.address[TAG_LSB +: TAG_W];
    words = {req.write_word_7, req.write_word_6, req.write_word_5, req.write_word_4,
             req.write_word_3, req.write_word_2, req.write_word_1, req.write_word_0};
    if (req.func == dmc_pkg::FUNC_ACCESS) begin
      // Only a hit touches the line; the read returns the old contents.
      if (line_valid[idx] && line_tag[idx] == tag) begin
        res.hit = 1'b1;
        if (req.read_enable) begin
          res = with_line_words(res, line_data[idx]);
        end
        if (req.write_enable) begin
          line_data[idx]  = words;
          line_dirty[idx] = 1'b1;
        end
      end
    end else begin
      // An insert evicts a dirty line with its rebuilt address.
      if (line_valid[idx] && line_dirty[idx]) begin
        res.writeback_needed  = 1'b1;
        res.writeback_address = {line_tag[idx], idx, {OFFSET_W{1'b0}}};
        res = with_line_words(res, line_data[idx]);
      end
      line_data[idx]  = words;
      line_valid[idx] = 1'b1;
      line_dirty[idx] = 1'b0;
      line_tag[idx]   = tag;
    end
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] got);
    if (got !== exp) begin
      if (mismatches < 10) begin
        $display("Mismatch on %s: expected %h, got %h", name, exp, got);
      end
      mismatches++;
    end
  endtask

  task automatic compare_result(dmc_pkg::out_t exp, dmc_pkg::out_t got);
    check_field("hit", 32'(exp.hit), 32'(got.hit));
    check_field("writeback_needed", 32'(exp.writeback_needed),
                32'(got.writeback_needed));
    check_field("writeback_address", exp.writeback_address, got.writeback_address);
    check_field("line_word_0", exp.line_word_0, got.line_word_0);
    check_field("line_word_1", exp.line_word_1, got.line_word_1);
    check_field("line_word_2", exp.line_word_2, got.line_word_2);
    check_field("line_word_3", exp.line_word_3, got.line_word_3);
    check_field("line_word_4", exp.line_word_4, got.line_word_4);
    check_field("line_word_5", exp.line_word_5, got.line_word_5);
    check_field("line_word_6", exp.line_word_6, got.line_word_6);
    check_field("line_word_7", exp.line_word_7, got.line_word_7);
  endtask

  // Results are taken before requests, since a request accepted at this edge
  // cannot have produced a result at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (line_valid[i]) begin
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
      end
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (mismatches < 10) begin
            $display("Result transfer with no request outstanding: %h", out_data);
          end
          mismatches++;
        end else begin
          compare_result(expected_results.pop_front(), out_data);
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_cache_result(in_data));
      end
    end
    mismatch_count <= mismatches;
    pending_count  <= expected_results.size();
  end

endmodule

FILE: sim/direct_mapped_writeback_cache_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache_top_test
// Drives directed and random access and insert requests into the cache,
// stalls the result channel at random and once for a long stretch, and gives
// the verdict from the checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache_top_test;

  localparam int CLK_PERIOD    = 4;
  localparam int RANDOM_ITEMS  = 1700;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AT_ITEM  = 400;
  localparam int CALM_FIRST    = 900;
  localparam int CALM_LAST     = 1200;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 400000;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  dmc_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  dmc_pkg::out_t out_data;

  int mismatch_count;
  int pending_count;

  // Items sent and the calm flag are shared between the sender and the receiver; the hold state is the receiver's own.
  int items_sent  = 0;
  bit calm_phase  = 1'b0;
  bit hold_done   = 1'b0;
  int hold_left   = 0;

  // Small pools of tags and indexes so that hits, evictions and back-to-back
  // transfers to one line are common.
  logic [11:0] tag_pool   [3];
  logic [14:0] index_pool [12];

  always #(CLK_PERIOD / 2) clk = ~clk;

  direct_mapped_writeback_cache_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  cache_result_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // Builds a request with every line word set to the same value.
  function automatic dmc_pkg::in_t make_request(logic func, logic [31:0] addr,
                                                logic rd, logic wr,
                                                logic [31:0] fill);
    dmc_pkg::in_t req;
    req              = '0;
    req.func         = func;
    req.address      = addr;
    req.read_enable  = rd;
    req.write_enable = wr;
    req.write_word_0 = fill;
    req.write_word_1 = fill;
    req.write_word_2 = fill;
    req.write_word_3 = fill;
    req.write_word_4 = fill;
    req.write_word_5 = fill;
    req.write_word_6 = fill;
    req.write_word_7 = fill;
    return req;
  endfunction

  // Mostly pooled addresses with random offsets; the rest anywhere at all.
  function automatic dmc_pkg::in_t random_request();
    dmc_pkg::in_t req;
    req = make_request(($urandom_range(99) < 40) ? dmc_pkg::FUNC_INSERT
                                                 : dmc_pkg::FUNC_ACCESS,
                       $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                       32'h0);
    if ($urandom_range(99) < 88) begin
      req.address = {tag_pool[2'($urandom_range(2))],
                     index_pool[4'($urandom_range(11))], 5'($urandom)};
    end
    req.write_word_0 = $urandom;
    req.write_word_1 = $urandom;
    req.write_word_2 = $urandom;
    req.write_word_3 = $urandom;
    req.write_word_4 = $urandom;
    req.write_word_5 = $urandom;
    req.write_word_6 = $urandom;
    req.write_word_7 = $urandom;
    return req;
  endfunction

  // Offers one request, with a random gap in front of it, and waits for the
  // transfer. Valid is left high so that the next request can follow at once.
  task automatic send_request(dmc_pkg::in_t req);
    int gap;
    gap = 0;
    if (!calm_phase) begin
      while (gap < 12 && $urandom_range(99) < 32) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    items_sent++;
  endtask

  // Result side: random stalls, one long hold-off, and a calm stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (calm_phase) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 32);
    end
  end

  // Watchdog.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL direct_mapped_writeback_cache_top");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    tag_pool[0] = 12'h000;
    tag_pool[1] = 12'hfff;
    tag_pool[2] = 12'($urandom);
    index_pool[0] = 15'h0000;
    index_pool[1] = 15'h7fff;
    for (int i = 2; i < 12; i++) index_pool[i] = 15'($urandom);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: misses on an empty cache, hits with and without read,
    // read and write together, clean and dirty evictions at both index ends.
    send_request(make_request(dmc_pkg::FUNC_ACCESS, 32'h0000_0000, 1'b1, 1'b1,
                              32'hffff_ffff));
    send_request(make_request(dmc_pkg::FUNC_INSERT, 32'hffff_ffff, 1'b0, 1'b0,
                              32'hffff_ffff));
    send_request(make_request(dmc_pkg::FUNC_ACCESS, 32'hffff_ffe0, 1'b1, 1'b0,
                              32'h0000_0000));
    send_request(make_request(dmc_pkg::FUNC_ACCESS, 32'hffff_fff3, 1'b0, 1'b0,
                              32'h0000_0000));
    send_request(make_request(dmc_pkg::FUNC_ACCESS, 32'hffff_ffe7, 1'b1, 1'b1,
                              32'h5a5a_a5a5));
    send_request(make_request(dmc_pkg::FUNC_ACCESS, 32'hffff_ffe0, 1'b1, 1'b0,
                              32'h0000_0000));
    send_request(make_request(dmc_pkg::FUNC_ACCESS, 32'h000f_ffe0, 1'b1, 1'b1,
                              32'h0000_0000));
    send_request(make_request(dmc_pkg::FUNC_INSERT, 32'h000f_ffe4, 1'b1, 1'b1,
                              32'h0000_0000));
    send_request(make_request(dmc_pkg::FUNC_INSERT, 32'h000f_ffe0, 1'b0, 1'b0,
                              32'h1234_5678));
    send_request(make_request(dmc_pkg::FUNC_ACCESS, 32'h000f_ffff, 1'b1, 1'b0,
                              32'hffff_ffff));
    send_request(make_request(dmc_pkg::FUNC_INSERT, 32'h0000_0000, 1'b0, 1'b0,
                              32'h0000_0000));
    send_request(make_request(dmc_pkg::FUNC_ACCESS, 32'h0000_001f, 1'b0, 1'b1,
                              32'hffff_ffff));
    send_request(make_request(dmc_pkg::FUNC_INSERT, 32'hfff0_0000, 1'b0, 1'b0,
                              32'h0000_0000));
    send_request(make_request(dmc_pkg::FUNC_ACCESS, 32'h0000_0000, 1'b1, 1'b0,
                              32'h0000_0000));
    send_request(make_request(dmc_pkg::FUNC_ACCESS, 32'hfff0_001c, 1'b1, 1'b0,
                              32'h0000_0000));
    send_request(make_request(dmc_pkg::FUNC_INSERT, 32'hfff0_0000, 1'b0, 1'b0,
                              32'ha5a5_5a5a));

    // Random part.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm_phase = (n >= CALM_FIRST && n < CALM_LAST);
      send_request(random_request());
    end
    calm_phase = 1'b0;
    in_valid <= 1'b0;

    // The checker's counts are registered, so let them settle after the last transfer.
    @(posedge clk);

    // Let every result arrive, then give the block time to show stray ones.
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("PASS direct_mapped_writeback_cache_top");
    end else begin
      $display("FAIL direct_mapped_writeback_cache_top");
    end
    $finish;
  end

endmodule

FILE: direct_mapped_writeback_cache_top.f
src/dmc_pkg.sv
src/dmc_ram.sv
src/dmc_resolve.sv
src/direct_mapped_writeback_cache_top.sv
sim/cache_result_checker.sv
sim/direct_mapped_writeback_cache_top_test.sv
